// ===== hdl/rau_pkg.sv =====
// Package for the rational arithmetic unit: operation and status codes,
// sequencer states and width constants. No dependencies.
`timescale 1ns / 1ps
package rau_pkg;
  localparam int unsigned DefWordBits = 32;
  localparam int unsigned MagBits = 64;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_EQ  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_OVF  = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_G_INIT, S_GCD, S_GCD_DONE, S_DIV, S_DIV_DONE,
    S_MUL, S_MUL_DONE, S_CHECK, S_OUT
  } state_t;
endpackage

// ===== hdl/rational_arithmetic_unit.sv =====
// Top level of the rational arithmetic unit: sequencer around one shared
// gcd/divide subtract-shift unit and one shift-add multiplier. Uses rau_pkg.
`timescale 1ns / 1ps
// Usage:
//   in_tdata carries one operation: two fractions and an op code. The block
//   takes it when in_tvalid and in_tready are high and then drops in_tready
//   until the result has been taken on the out_ channel.
//   One result transaction follows every input transaction, in order.
//   Latency is data dependent. A zero denominator, a divide by zero or an
//   undefined op code gives a result straight from the load state.
//   Otherwise the steps run on the shared units. Add and subtract run the
//   gcd of 32-bit denominators (up to ~46 steps) plus the reduction gcd on
//   64-bit values (up to ~92 steps); equality runs two gcds on 32-bit
//   values, multiply and divide the reduction gcd on 64-bit values.
//   The next input can be taken from the cycle after the result transaction.
//   The result is held in an output register while out_tready is low; the
//   sequencer waits in its output state until the transaction completes.
//   Reset (rst_n low, synchronous) returns the sequencer to idle with no
//   result pending. There is no clearing pass.
module rational_arithmetic_unit #(
  parameter int unsigned WORD_BITS = rau_pkg::DefWordBits
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // operation[2:0], a_num[34:3], a_den[66:35], b_num[98:67], b_den[130:99]
  input  logic [135:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // res_num[31:0], res_den[62:32], is_equal[63], status[65:64]
  output logic [71:0]  out_tdata
);
  import rau_pkg::*;

  localparam int unsigned FitBits = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam logic [MagBits-1:0] Lim = MagBits'(1) << (FitBits - 1);

  // micro-program step within an operation
  typedef enum logic [3:0] {
    P_EQ_GA, P_EQ_AM, P_EQ_AD, P_EQ_GB, P_EQ_BM, P_EQ_BD,
    P_AS_G, P_AS_Q, P_AS_L, P_AS_QA, P_AS_TA, P_AS_QB, P_AS_TB,
    P_R_G, P_R_M, P_R_D
  } prog_t;

  state_t state_r, state_nxt;
  prog_t  pc_r, pc_nxt;

  logic [2:0]  op_r;
  logic        an_r, bn_r, rn_r;
  logic [MagBits-1:0] am_r, ad_r, bm_r, bd_r, rm_r, rd_r;
  logic [MagBits-1:0] t0_r, t1_r;  // scratch: lcm, ta
  logic [MagBits-1:0] ga_r, gb_r;  // gcd work pair
  logic [MagBits-1:0] dn_r, dd_r, q_r, rem_r;  // divider
  logic [6:0]  cnt_r;
  logic [MagBits-1:0] ma_r, mb_r, mp_r;  // multiplier
  logic [71:0] out_r;

  logic [MagBits-1:0] q_res;  // result routing from units
  logic [MagBits-1:0] mul_x, mul_y, div_n, div_d;
  logic [MagBits:0]   rem_sh;
  logic [MagBits-1:0] gres;

  // ---- operand unpack
  logic [31:0] i_an, i_ad, i_bn, i_bd;
  assign i_an = in_tdata[34:3];
  assign i_ad = in_tdata[66:35];
  assign i_bn = in_tdata[98:67];
  assign i_bd = in_tdata[130:99];

  function automatic logic [MagBits-1:0] mag32(input logic [31:0] v);
    logic [32:0] m;
    m = v[31] ? (33'h1_0000_0000 - {1'b0, v}) : {1'b0, v};
    return MagBits'(m);
  endfunction

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = out_r;

  assign rem_sh = {rem_r, dn_r[MagBits-1]};
  assign gres = ga_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    pc_nxt = pc_r;
    case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_LOAD;
      S_LOAD: begin
        if (op_r > 3'(OP_EQ) || ad_r == '0 || bd_r == '0 ||
            (op_r == 3'(OP_DIV) && bm_r == '0)) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_G_INIT;
          case (op_r)
            3'(OP_EQ): pc_nxt = P_EQ_GA;
            3'(OP_ADD), 3'(OP_SUB): pc_nxt = P_AS_G;
            default: begin
              state_nxt = S_MUL;
              pc_nxt = P_AS_G;  // first of two products
            end
          endcase
        end
      end
      S_G_INIT: begin
        case (pc_r)
          P_EQ_GA, P_EQ_GB, P_AS_G, P_R_G: state_nxt = S_GCD;
          P_AS_TA, P_AS_TB: state_nxt = S_MUL;
          default: state_nxt = S_DIV;
        endcase
      end
      S_GCD: if (gb_r == '0) state_nxt = S_GCD_DONE; else state_nxt = S_DIV;
      S_DIV: if (cnt_r == 7'd64) state_nxt = S_DIV_DONE;
      S_DIV_DONE: begin
        if (pc_r == P_EQ_GA || pc_r == P_EQ_GB || pc_r == P_AS_G ||
            pc_r == P_R_G) begin
          state_nxt = S_GCD;
        end else begin
          state_nxt = S_G_INIT;
          case (pc_r)
            P_EQ_AM: pc_nxt = P_EQ_AD;
            P_EQ_AD: pc_nxt = P_EQ_GB;
            P_EQ_BM: pc_nxt = P_EQ_BD;
            P_EQ_BD: state_nxt = S_CHECK;
            P_AS_Q:  pc_nxt = P_AS_L;
            P_AS_QA: pc_nxt = P_AS_TA;
            P_AS_QB: pc_nxt = P_AS_TB;
            P_R_M:   pc_nxt = P_R_D;
            default: state_nxt = S_CHECK;
          endcase
          if (pc_r == P_AS_Q) state_nxt = S_MUL;
        end
      end
      S_GCD_DONE: begin
        state_nxt = S_G_INIT;
        case (pc_r)
          P_EQ_GA: pc_nxt = P_EQ_AM;
          P_EQ_GB: pc_nxt = P_EQ_BM;
          P_AS_G:  pc_nxt = P_AS_Q;
          default: pc_nxt = P_R_M;
        endcase
      end
      S_MUL: if (cnt_r == 7'd63) state_nxt = S_MUL_DONE;
      S_MUL_DONE: begin
        state_nxt = S_G_INIT;
        case (pc_r)
          P_AS_L:  pc_nxt = P_AS_QA;
          P_AS_TA: pc_nxt = P_AS_QB;
          P_AS_TB: pc_nxt = P_R_G;
          P_AS_G: begin  // mul/div: numerator product done
            pc_nxt = P_AS_Q;
            state_nxt = S_MUL;
          end
          default: pc_nxt = P_R_G;  // mul/div: denominator product done
        endcase
      end
      S_CHECK: state_nxt = S_OUT;
      S_OUT: if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // operand selection for the shared units
  always_comb begin
    mul_x = am_r;
    mul_y = bm_r;
    div_n = ad_r;
    div_d = ga_r;
    case (pc_r)
      P_AS_L:  begin mul_x = q_r;  mul_y = bd_r; end
      P_AS_TA: begin mul_x = am_r; mul_y = q_r;  end
      P_AS_TB: begin mul_x = bm_r; mul_y = q_r;  end
      P_AS_G:  begin
        mul_x = am_r;
        mul_y = (op_r == 3'(OP_DIV)) ? bd_r : bm_r;
      end
      P_AS_Q:  begin
        mul_x = ad_r;
        mul_y = (op_r == 3'(OP_DIV)) ? bm_r : bd_r;
      end
      default: ;
    endcase
    case (pc_r)
      P_EQ_AM: begin div_n = am_r; div_d = gres; end
      P_EQ_AD: begin div_n = ad_r; div_d = gres; end
      P_EQ_BM: begin div_n = bm_r; div_d = gres; end
      P_EQ_BD: begin div_n = bd_r; div_d = gres; end
      P_AS_Q:  begin div_n = ad_r; div_d = gres; end
      P_AS_QA: begin div_n = t0_r; div_d = ad_r; end
      P_AS_QB: begin div_n = t0_r; div_d = bd_r; end
      P_R_M:   begin div_n = rm_r; div_d = gres; end
      P_R_D:   begin div_n = rd_r; div_d = gres; end
      default: ;
    endcase
  end

  assign q_res = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r <= P_EQ_GA;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r <= pc_nxt;
      if (state_r == S_DIV || state_r == S_MUL) cnt_r <= cnt_r + 7'd1;
      else cnt_r <= '0;
    end
  end

  logic [MagBits-1:0] sa, sb;
  logic bneg;
  logic fits;
  logic zero_den;
  logic eq_bit;
  logic [31:0] num32;
  always_comb begin
    bneg = (op_r == 3'(OP_SUB)) ? !bn_r : bn_r;
    sa = t1_r;
    sb = mp_r;
    fits = (rd_r <= Lim - 1) && (rn_r ? (rm_r <= Lim) : (rm_r <= Lim - 1));
    zero_den = (op_r <= 3'(OP_EQ)) &&
               (ad_r == '0 || bd_r == '0 || (op_r == 3'(OP_DIV) && bm_r == '0));
    eq_bit = (an_r == bn_r || am_r == '0) && am_r == bm_r && ad_r == bd_r;
    num32 = (rn_r && rm_r != '0) ? 32'(-rm_r) : rm_r[31:0];
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: if (in_tvalid) begin
        op_r <= in_tdata[2:0];
        am_r <= mag32(i_an);
        ad_r <= mag32(i_ad);
        bm_r <= mag32(i_bn);
        bd_r <= mag32(i_bd);
        an_r <= i_an[31] ^ i_ad[31];
        bn_r <= i_bn[31] ^ i_bd[31];
      end
      S_LOAD: begin
        if (zero_den) out_r <= {6'd0, ST_ZERO, 64'd0};
        else out_r <= '0;
        rn_r <= an_r ^ bn_r;
        // first product setup for multiply/divide
        ma_r <= am_r;
        mb_r <= (op_r == 3'(OP_DIV)) ? bd_r : bm_r;
        mp_r <= '0;
      end
      S_G_INIT: begin
        case (pc_r)
          P_EQ_GA: begin ga_r <= am_r; gb_r <= ad_r; end
          P_EQ_GB: begin ga_r <= bm_r; gb_r <= bd_r; end
          P_AS_G:  begin ga_r <= ad_r; gb_r <= bd_r; end
          P_R_G:   begin ga_r <= rm_r; gb_r <= rd_r; end
          default: ;
        endcase
        if (pc_r != P_EQ_GA && pc_r != P_EQ_GB && pc_r != P_AS_G &&
            pc_r != P_R_G && pc_r != P_AS_TA && pc_r != P_AS_TB) begin
          dn_r <= div_n;
          dd_r <= div_d;
          rem_r <= '0;
          q_r <= '0;
        end
        if (pc_r == P_AS_TA || pc_r == P_AS_TB) begin
          ma_r <= mul_x;
          mb_r <= mul_y;
          mp_r <= '0;
        end
      end
      S_GCD: if (gb_r != '0) begin
        dn_r <= ga_r;
        dd_r <= gb_r;
        rem_r <= '0;
        q_r <= '0;
      end
      S_DIV: begin
        // restoring divide, one quotient bit per cycle
        if (cnt_r != 7'd64) begin
          if (rem_sh >= {1'b0, dd_r}) begin
            rem_r <= MagBits'(rem_sh - {1'b0, dd_r});
            q_r <= {q_r[MagBits-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh[MagBits-1:0];
            q_r <= {q_r[MagBits-2:0], 1'b0};
          end
          dn_r <= {dn_r[MagBits-2:0], 1'b0};
        end
      end
      S_DIV_DONE: begin
        case (pc_r)
          P_EQ_GA, P_EQ_GB, P_AS_G, P_R_G: begin
            ga_r <= gb_r;
            gb_r <= rem_r;
          end
          P_EQ_AM: am_r <= q_res;
          P_EQ_AD: ad_r <= q_res;
          P_EQ_BM: bm_r <= q_res;
          P_EQ_BD: bd_r <= q_res;
          P_R_M:   rm_r <= q_res;
          P_R_D:   rd_r <= q_res;
          default: ;
        endcase
        if (pc_r == P_AS_Q) begin
          ma_r <= q_res;
          mb_r <= bd_r;
          mp_r <= '0;
        end
      end
      S_GCD_DONE: ;
      S_MUL: begin
        if (mb_r[0]) mp_r <= mp_r + ma_r;
        ma_r <= {ma_r[MagBits-2:0], 1'b0};
        mb_r <= {1'b0, mb_r[MagBits-1:1]};
      end
      S_MUL_DONE: begin
        case (pc_r)
          P_AS_L:  t0_r <= mp_r;
          P_AS_TA: t1_r <= mp_r;
          P_AS_TB: begin
            rd_r <= t0_r;
            if (an_r == bneg) begin
              rn_r <= an_r; rm_r <= sa + sb;
            end else if (sa >= sb) begin
              rn_r <= an_r; rm_r <= sa - sb;
            end else begin
              rn_r <= bneg; rm_r <= sb - sa;
            end
          end
          P_AS_G: begin
            rm_r <= mp_r;
            ma_r <= ad_r;
            mb_r <= (op_r == 3'(OP_DIV)) ? bm_r : bd_r;
            mp_r <= '0;
          end
          default: rd_r <= mp_r;
        endcase
      end
      S_CHECK: begin
        if (op_r == 3'(OP_EQ)) out_r <= {6'd0, ST_OK, eq_bit, 63'd0};
        else if (!fits) out_r <= {6'd0, ST_OVF, 64'd0};
        else out_r <= {6'd0, ST_OK, 1'b0, rd_r[30:0], num32};
      end
      default: ;
    endcase
  end
endmodule

// ===== hdl/rau_checker.sv =====
// Port-level checker for rational_arithmetic_unit, bound to the top level.
// Depends on rau_pkg for status codes.
`timescale 1ns / 1ps
module rau_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);
  import rau_pkg::*;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while result pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("accepted a second item while busy");

  a_err_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[65:64] != ST_OK) |-> (out_tdata[63:0] == '0))
    else $error("error result carries data");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[65:64] != 2'd3))
    else $error("illegal status code");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result dropped during stall");
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

// ===== verif/rational_arithmetic_unit_tb.sv =====
// Self-checking testbench for the rational arithmetic unit: directed table
// plus random operations, each result compared with a fraction predictor.
// Depends on rau_pkg and rational_arithmetic_unit.
`timescale 1ns / 1ps
module rational_arithmetic_unit_tb;
  import rau_pkg::*;

  typedef struct packed {
    logic [31:0] b_den;
    logic [31:0] b_num;
    logic [31:0] a_den;
    logic [31:0] a_num;
    logic [2:0]  operation;
  } frac_op_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        is_equal;
    logic [30:0] res_den;
    logic [31:0] res_num;
  } frac_res_t;

  typedef struct {
    frac_op_t  op;
    logic      has_exp;
    frac_res_t exp;
  } dir_row_t;

  localparam int unsigned MaxCycles = 40000000;
  localparam int unsigned RandItems = 700;
  localparam int unsigned HoldOffCycles = 30000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [71:0]  out_tdata;

  frac_res_t    pending_results[$];
  int unsigned  fail_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  send_idle_pct = 9;
  int unsigned  recv_idle_pct = 66;
  int unsigned  hold_off_cycles = 0;
  logic         hold_off_start = 1'b0;
  logic         hold_off_used = 1'b0;

  rational_arithmetic_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #1 clk = ~clk;

  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic void to_sign_mag(logic [31:0] v, output logic neg,
                                      output logic [63:0] mag);
    neg = v[31];
    mag = v[31] ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
  endfunction

  function automatic void reduce_frac(inout logic neg, inout logic [63:0] mag,
                                      inout logic [63:0] den);
    logic [63:0] g;
    g = gcd64(mag, den);
    if (g != 0) begin
      mag = mag / g;
      den = den / g;
    end
    if (mag == 0) neg = 1'b0;
  endfunction

  function automatic frac_res_t predict_fraction(frac_op_t op);
    frac_res_t r;
    logic an, ad, bn, bd, a_neg, b_neg, r_neg, bneg_eff;
    logic [63:0] a_mag, a_den, b_mag, b_den, r_mag, r_den, g, l, ta, tb;
    r = '0;
    if (op.operation > OP_EQ) return r;
    to_sign_mag(op.a_num, an, a_mag);
    to_sign_mag(op.a_den, ad, a_den);
    to_sign_mag(op.b_num, bn, b_mag);
    to_sign_mag(op.b_den, bd, b_den);
    a_neg = an ^ ad;
    b_neg = bn ^ bd;
    if (a_den == 0 || b_den == 0) begin
      r.status = ST_ZERO;
      return r;
    end
    case (op.operation)
      OP_EQ: begin
        reduce_frac(a_neg, a_mag, a_den);
        reduce_frac(b_neg, b_mag, b_den);
        r.is_equal = (a_neg == b_neg) && (a_mag == b_mag) && (a_den == b_den);
        return r;
      end
      OP_ADD, OP_SUB: begin
        g = gcd64(a_den, b_den);
        l = (a_den / g) * b_den;
        ta = a_mag * (l / a_den);
        tb = b_mag * (l / b_den);
        bneg_eff = (op.operation == OP_SUB) ? !b_neg : b_neg;
        if (a_neg == bneg_eff) begin
          r_neg = a_neg; r_mag = ta + tb;
        end else if (ta >= tb) begin
          r_neg = a_neg; r_mag = ta - tb;
        end else begin
          r_neg = bneg_eff; r_mag = tb - ta;
        end
        r_den = l;
      end
      OP_MUL: begin
        r_neg = a_neg ^ b_neg;
        r_mag = a_mag * b_mag;
        r_den = a_den * b_den;
      end
      default: begin
        if (b_mag == 0) begin
          r.status = ST_ZERO;
          return r;
        end
        r_neg = a_neg ^ b_neg;
        r_mag = a_mag * b_den;
        r_den = a_den * b_mag;
      end
    endcase
    reduce_frac(r_neg, r_mag, r_den);
    if (r_den > 64'h7FFF_FFFF || (r_neg ? r_mag > 64'h8000_0000
                                        : r_mag > 64'h7FFF_FFFF)) begin
      r.status = ST_OVF;
      return r;
    end
    r.res_num = r_neg ? (32'd0 - r_mag[31:0]) : r_mag[31:0];
    r.res_den = r_den[30:0];
    return r;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 12) - 6;
      1: return $urandom_range(1, 1000);
      2: return -$urandom_range(1, 1000);
      3: return {1'($urandom_range(0, 1)), 31'd0} |
                ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'd1);
      default: return $urandom();
    endcase
  endfunction

  function automatic frac_op_t rand_op();
    frac_op_t op;
    op.operation = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4));
    op.a_num = rand_word();
    op.a_den = rand_word();
    op.b_num = rand_word();
    op.b_den = rand_word();
    // keep zero denominators rare so arithmetic paths dominate
    if (op.a_den == 0 && $urandom_range(0, 3) != 0) op.a_den = 32'd7;
    if (op.b_den == 0 && $urandom_range(0, 3) != 0) op.b_den = -32'sd3;
    if (op.operation == OP_EQ && $urandom_range(0, 1)) begin
      op.b_num = op.a_num * 3;
      op.b_den = op.a_den * 3;
    end
    return op;
  endfunction

  function automatic dir_row_t row(op_t o, int an, int ad, int bn, int bd,
                                   logic has, frac_res_t e);
    dir_row_t d;
    d.op = '{b_den: bd, b_num: bn, a_den: ad, a_num: an, operation: o};
    d.has_exp = has;
    d.exp = e;
    return d;
  endfunction

  // valid stays high between back-to-back transactions; it drops only
  // while the sender idles
  task automatic send_op(frac_op_t op, frac_res_t exp);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'd0, op};
    pending_results.push_back(exp);
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // long receiver hold-off counter
  always @(posedge clk) begin
    if (hold_off_start && !hold_off_used) begin
      hold_off_used <= 1'b1;
      hold_off_cycles <= HoldOffCycles;
    end else if (hold_off_cycles != 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
    end
  end

  // receiver: random stalls plus the long hold-off
  always @(posedge clk) begin
    if (hold_off_cycles != 0 || (hold_off_start && !hold_off_used)) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    frac_res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[65:0];
      if (pending_results.size() == 0) begin
        $error("result with no expectation: %h", got);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.res_num !== want.res_num) begin
          $error("res_num exp %0d got %0d", $signed(want.res_num), $signed(got.res_num));
          fail_count++;
        end
        if (got.res_den !== want.res_den) begin
          $error("res_den exp %0d got %0d", want.res_den, got.res_den);
          fail_count++;
        end
        if (got.is_equal !== want.is_equal) begin
          $error("is_equal exp %0b got %0b", want.is_equal, got.is_equal);
          fail_count++;
        end
        if (got.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, got.status);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MaxCycles) begin
      $display("FAIL rational_arithmetic_unit");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_rows[$];
    frac_res_t none;
    frac_op_t rop;
    none = '0;
    dir_rows.push_back(row(OP_ADD, 1, 2, 1, 3, 1, '{ST_OK, 1'b0, 31'd6, 32'd5}));
    dir_rows.push_back(row(OP_SUB, 1, 2, 1, 2, 1, '{ST_OK, 1'b0, 31'd1, 32'd0}));
    dir_rows.push_back(row(OP_MUL, -2, 4, 3, -9, 1, '{ST_OK, 1'b0, 31'd6, 32'd1}));
    dir_rows.push_back(row(OP_DIV, 1, 2, 0, 5, 1, '{ST_ZERO, 1'b0, 31'd0, 32'd0}));
    dir_rows.push_back(row(OP_ADD, 1, 0, 1, 1, 1, '{ST_ZERO, 1'b0, 31'd0, 32'd0}));
    dir_rows.push_back(row(OP_EQ, 1, 1, 1, 0, 1, '{ST_ZERO, 1'b0, 31'd0, 32'd0}));
    dir_rows.push_back(row(OP_EQ, 2, 4, -3, -6, 1, '{ST_OK, 1'b1, 31'd0, 32'd0}));
    dir_rows.push_back(row(OP_EQ, 2, 4, 3, -6, 1, '{ST_OK, 1'b0, 31'd0, 32'd0}));
    dir_rows.push_back(row(OP_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1, 1,
                           '{ST_OVF, 1'b0, 31'd0, 32'd0}));
    dir_rows.push_back(row(OP_ADD, 32'h7FFF_FFFF, 1, 1, 1, 1,
                           '{ST_OVF, 1'b0, 31'd0, 32'd0}));
    dir_rows.push_back(row(OP_SUB, 32'h8000_0000, 1, 0, 1, 0, none));
    dir_rows.push_back(row(OP_DIV, 32'h8000_0000, 1, -1, 1, 0, none));
    dir_rows.push_back(row(OP_DIV, 1, 32'h8000_0000, 1, 32'h7FFF_FFFF, 0, none));
    dir_rows.push_back(row(OP_ADD, 0, -5, 0, 32'h8000_0000, 0, none));
    dir_rows.push_back(row(OP_SUB, -1, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFE, 0, none));
    dir_rows.push_back(row(OP_MUL, -1, -1, -1, -1, 0, none));
    dir_rows.push_back(row(OP_DIV, 7, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, none));
    dir_rows.push_back(row(op_t'(3'd5), 1, 1, 1, 1, 1, none));
    dir_rows.push_back(row(op_t'(3'd7), 0, 0, 0, 0, 1, none));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].has_exp && predict_fraction(dir_rows[i].op) !== dir_rows[i].exp) begin
        $error("table row %0d disagrees with predictor", i);
        fail_count++;
      end
      send_op(dir_rows[i].op, dir_rows[i].has_exp ? dir_rows[i].exp
                                                  : predict_fraction(dir_rows[i].op));
    end
    drain();

    // long receiver stall while the sender keeps offering
    hold_off_start = 1'b1;
    for (int i = 0; i < 6; i++) begin
      rop = rand_op();
      send_op(rop, predict_fraction(rop));
    end
    drain();

    for (int i = 0; i < RandItems; i++) begin
      if (i == RandItems / 3) begin
        send_idle_pct = 66;
        recv_idle_pct = 9;
      end else if (i == 2 * RandItems / 3) begin
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      rop = rand_op();
      send_op(rop, predict_fraction(rop));
    end
    drain();
    repeat (200) @(posedge clk);

    if (fail_count == 0 && pending_results.size() == 0)
      $display("PASS rational_arithmetic_unit");
    else
      $display("FAIL rational_arithmetic_unit");
    $finish;
  end
endmodule
